/* src/uti_pkg.sv */
`timescale 1ns / 1ps

package uti_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int FRAC_BITS   = 16;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int DATA_W      = 32;
   localparam int INDEX_W     = 10;
   localparam int CNT_W       = 11;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int WHOLE_W     = PROD_W - 2 * FRAC_BITS;
   localparam int DIFF_W      = DATA_W + 1;
   localparam int BLEND_W     = DIFF_W + FRAC_BITS + 1;

   localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;
   localparam logic [DATA_W-1:0] SCALE_RESET = DATA_W'(1) << FRAC_BITS;

   // configuration register indexes
   localparam logic [1:0] CSR_T_MIN       = 2'd0;
   localparam logic [1:0] CSR_INDEX_SCALE = 2'd1;
   localparam logic [1:0] CSR_ENTRY_COUNT = 2'd2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   localparam logic [1:0] FLAG_INSIDE = 2'd0;
   localparam logic [1:0] FLAG_BELOW  = 2'd1;
   localparam logic [1:0] FLAG_ABOVE  = 2'd2;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] position;
      logic [INDEX_W-1:0]       entry_index;
      logic signed [DATA_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [1:0]               clamp_flag;
   } rsp_type;

   // decoded lookup or table write, ready for the table stage
   typedef struct packed {
      logic                     valid;
      logic                     is_write;
      logic [ADDR_W-1:0]        addr0;
      logic [ADDR_W-1:0]        addr1;
      logic [FRAC_BITS-1:0]     frac;
      logic [1:0]               flag;
      logic signed [DATA_W-1:0] wdata;
   } look_type;

   // two neighboring entries read for one lookup
   typedef struct packed {
      logic                     valid;
      logic [FRAC_BITS-1:0]     frac;
      logic [1:0]               flag;
      logic signed [DATA_W-1:0] e0;
      logic signed [DATA_W-1:0] e1;
   } pair_type;

endpackage

/* src/uti_index.sv */
`timescale 1ns / 1ps

module uti_index (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  uti_pkg::req_type                   in_data,
   input  logic signed [uti_pkg::DATA_W-1:0]  t_min,
   input  logic [uti_pkg::DATA_W-1:0]         index_scale,
   input  logic [uti_pkg::ADDR_W-1:0]         last,
   output uti_pkg::look_type                  look
);

   // stage 1: offset from t_min, split into sign and magnitude
   logic                               s1_valid_ff;
   logic                               s1_op_ff;
   logic                               s1_neg_ff;
   logic [uti_pkg::DATA_W-1:0]         s1_mag_ff;
   logic [uti_pkg::ADDR_W-1:0]         s1_addr_ff;
   logic signed [uti_pkg::DATA_W-1:0]  s1_wdata_ff;

   // stage 2: scaled index
   logic                               s2_valid_ff;
   logic                               s2_op_ff;
   logic                               s2_neg_ff;
   logic [uti_pkg::PROD_W-1:0]         s2_prod_ff;
   logic [uti_pkg::ADDR_W-1:0]         s2_addr_ff;
   logic signed [uti_pkg::DATA_W-1:0]  s2_wdata_ff;

   uti_pkg::look_type                  look_ff;
   uti_pkg::look_type                  look_in;

   logic [uti_pkg::DATA_W:0]           diff_in;
   logic [uti_pkg::DATA_W:0]           abs_in;
   logic                               in_range_in;
   logic [uti_pkg::PROD_W-1:0]         prod_in;
   logic [uti_pkg::WHOLE_W-1:0]        whole;
   logic [uti_pkg::WHOLE_W-1:0]        last_ext;
   logic [uti_pkg::FRAC_BITS-1:0]      frac;

   assign diff_in = {in_data.position[uti_pkg::DATA_W-1], in_data.position}
                  - {t_min[uti_pkg::DATA_W-1], t_min};
   assign abs_in  = diff_in[uti_pkg::DATA_W] ? (~diff_in + 1'b1) : diff_in;
   // a 10-bit entry_index always lies inside the table, so the range check drops no write
   assign in_range_in = (32'(in_data.entry_index) < 32'(uti_pkg::TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid && (in_data.op == uti_pkg::OP_LOOKUP || in_range_in);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= in_data.op;
         s1_neg_ff   <= diff_in[uti_pkg::DATA_W];
         s1_mag_ff   <= abs_in[uti_pkg::DATA_W-1:0];
         s1_addr_ff  <= uti_pkg::ADDR_W'(in_data.entry_index);
         s1_wdata_ff <= in_data.entry_value;
      end
   end

   assign prod_in = uti_pkg::PROD_W'(s1_mag_ff) * uti_pkg::PROD_W'(index_scale);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_op_ff    <= s1_op_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_prod_ff  <= prod_in;
         s2_addr_ff  <= s1_addr_ff;
         s2_wdata_ff <= s1_wdata_ff;
      end
   end

   assign whole    = s2_prod_ff[uti_pkg::PROD_W-1:2*uti_pkg::FRAC_BITS];
   assign frac     = s2_prod_ff[2*uti_pkg::FRAC_BITS-1:uti_pkg::FRAC_BITS];
   assign last_ext = uti_pkg::WHOLE_W'(last);

   // clamped cases read one entry twice with a zero fraction
   always_comb begin
      look_in.valid    = s2_valid_ff;
      look_in.is_write = (s2_op_ff == uti_pkg::OP_WRITE);
      look_in.wdata    = s2_wdata_ff;
      look_in.frac     = '0;
      look_in.flag     = uti_pkg::FLAG_INSIDE;
      if (s2_op_ff == uti_pkg::OP_WRITE) begin
         look_in.addr0 = s2_addr_ff;
         look_in.addr1 = s2_addr_ff;
      end else if (s2_neg_ff && s2_prod_ff != '0) begin
         look_in.addr0 = '0;
         look_in.addr1 = '0;
         look_in.flag  = uti_pkg::FLAG_BELOW;
      end else if (whole > last_ext || (whole == last_ext && frac != '0)) begin
         look_in.addr0 = last;
         look_in.addr1 = last;
         look_in.flag  = uti_pkg::FLAG_ABOVE;
      end else if (whole == last_ext) begin
         look_in.addr0 = last;
         look_in.addr1 = last;
      end else begin
         look_in.addr0 = whole[uti_pkg::ADDR_W-1:0];
         look_in.addr1 = whole[uti_pkg::ADDR_W-1:0] + 1'b1;
         look_in.frac  = frac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff.valid <= 1'b0;
      end else if (advance) begin
         look_ff.valid <= look_in.valid;
      end
      if (advance) begin
         look_ff.is_write <= look_in.is_write;
         look_ff.addr0    <= look_in.addr0;
         look_ff.addr1    <= look_in.addr1;
         look_ff.frac     <= look_in.frac;
         look_ff.flag     <= look_in.flag;
         look_ff.wdata    <= look_in.wdata;
      end
   end

   assign look = look_ff;

endmodule

/* src/uti_table.sv */
`timescale 1ns / 1ps

module uti_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  uti_pkg::look_type   look,
   output uti_pkg::pair_type   pair
);

   logic signed [uti_pkg::DATA_W-1:0] sample_table_ff [uti_pkg::TABLE_DEPTH];
   uti_pkg::pair_type                 pair_ff;

   // writes land here, in order with the lookups around them
   always_ff @(posedge clock) begin
      if (advance && look.valid && look.is_write) begin
         sample_table_ff[look.addr0] <= look.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff.e0   <= sample_table_ff[look.addr0];
         pair_ff.e1   <= sample_table_ff[look.addr1];
         pair_ff.frac <= look.frac;
         pair_ff.flag <= look.flag;
      end
      if (reset) begin
         pair_ff.valid <= 1'b0;
      end else if (advance) begin
         pair_ff.valid <= look.valid && !look.is_write;
      end
   end

   assign pair = pair_ff;

endmodule

/* src/uti_blend.sv */
`timescale 1ns / 1ps

module uti_blend (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  uti_pkg::pair_type  pair,
   output logic               out_valid,
   output uti_pkg::rsp_type   out_data
);

   logic                                b1_valid_ff;
   logic signed [uti_pkg::DIFF_W-1:0]   b1_diff_ff;
   logic signed [uti_pkg::DATA_W-1:0]   b1_e0_ff;
   logic [uti_pkg::FRAC_BITS-1:0]       b1_frac_ff;
   logic [1:0]                          b1_flag_ff;

   logic                                b2_valid_ff;
   logic signed [uti_pkg::BLEND_W-1:0]  b2_prod_ff;
   logic signed [uti_pkg::DATA_W-1:0]   b2_e0_ff;
   logic [1:0]                          b2_flag_ff;

   logic                                out_valid_ff;
   uti_pkg::rsp_type                    out_data_ff;

   logic signed [uti_pkg::DIFF_W-1:0]   diff_in;
   logic signed [uti_pkg::BLEND_W-1:0]  prod_in;
   logic signed [uti_pkg::BLEND_W-1:0]  step;
   logic signed [uti_pkg::DATA_W-1:0]   value_in;

   assign diff_in = {pair.e1[uti_pkg::DATA_W-1], pair.e1}
                  - {pair.e0[uti_pkg::DATA_W-1], pair.e0};

   assign prod_in = b1_diff_ff * $signed({1'b0, b1_frac_ff});

   // arithmetic shift gives the floor; the sum always stays inside 32 bits
   assign step     = b2_prod_ff >>> uti_pkg::FRAC_BITS;
   assign value_in = b2_e0_ff + step[uti_pkg::DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= pair.valid;
         b2_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_diff_ff             <= diff_in;
         b1_e0_ff               <= pair.e0;
         b1_frac_ff             <= pair.frac;
         b1_flag_ff             <= pair.flag;
         b2_prod_ff             <= prod_in;
         b2_e0_ff               <= b1_e0_ff;
         b2_flag_ff             <= b1_flag_ff;
         out_data_ff.value      <= value_in;
         out_data_ff.clamp_flag <= b2_flag_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

/* src/uniform_table_linear_interp.sv */
`timescale 1ns / 1ps
// Sampled table with linear interpolation between neighboring entries.
// req channel: op selects a table write (entry_index, entry_value) or a
// lookup at a Q16.16 position. Writes give no response; each lookup gives
// one rsp transaction with the blended value and a clamp flag (below /
// above the table). Responses come back in request order.
// Throughput: one transaction per cycle while rsp_stall does not freeze the
// pipeline; the seven stages are offset, 32x32 scale multiply, index
// decode, dual-read table, difference, blend multiply, output register.
// A write updates the table when it reaches the table stage, so any later
// lookup sees it. Lookups must only touch entries already written.
// csr port: t_min, index_scale, entry_count; write only while idle.
// Reset (synchronous) empties the pipeline and restores the registers;
// table contents are not cleared.
// rsp_stall freezes the whole pipeline while a response waits, and
// req_stall is raised for as long as that lasts; a bubble in the output
// register never blocks the input.
module uniform_table_linear_interp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  uti_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output uti_pkg::rsp_type            rsp_data,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [uti_pkg::DATA_W-1:0]  csr_wdata
);

   logic signed [uti_pkg::DATA_W-1:0] t_min_ff;
   logic [uti_pkg::DATA_W-1:0]        index_scale_ff;
   logic [uti_pkg::CNT_W-1:0]         entry_count_ff;
   logic [uti_pkg::ADDR_W-1:0]        last;
   logic                              advance;
   uti_pkg::look_type                 look;
   uti_pkg::pair_type                 pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_min_ff       <= '0;
         index_scale_ff <= uti_pkg::SCALE_RESET;
         entry_count_ff <= uti_pkg::COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            uti_pkg::CSR_T_MIN:       t_min_ff       <= csr_wdata;
            uti_pkg::CSR_INDEX_SCALE: index_scale_ff <= csr_wdata;
            uti_pkg::CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[uti_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // index of the last entry in use, count held to 2..TABLE_DEPTH
   always_comb begin
      if (entry_count_ff < uti_pkg::CNT_W'(2)) begin
         last = uti_pkg::ADDR_W'(1);
      end else if (32'(entry_count_ff) > 32'(uti_pkg::TABLE_DEPTH)) begin
         last = uti_pkg::ADDR_W'(uti_pkg::TABLE_DEPTH - 1);
      end else begin
         last = uti_pkg::ADDR_W'(entry_count_ff - 1'b1);
      end
   end

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   uti_index u_index (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .in_data     (req_data),
      .t_min       (t_min_ff),
      .index_scale (index_scale_ff),
      .last        (last),
      .look        (look)
   );

   uti_table u_table (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .look    (look),
      .pair    (pair)
   );

   uti_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pair      (pair),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_accept_while_blocked: assert property (@(posedge clock)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input accepted while the output register is blocked");

   a_flag_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.clamp_flag == uti_pkg::FLAG_INSIDE ||
                     rsp_data.clamp_flag == uti_pkg::FLAG_BELOW ||
                     rsp_data.clamp_flag == uti_pkg::FLAG_ABOVE))
      else $error("clamp flag carries an unused code");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !look.valid && !pair.valid))
      else $error("pipeline not empty after reset");

   a_clamped_no_blend: assert property (@(posedge clock) disable iff (reset)
      (pair.valid && pair.flag != uti_pkg::FLAG_INSIDE) |-> (pair.frac == '0))
      else $error("clamped lookup carries a nonzero fraction");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int     SETTLE_CYCLES = 12;
   localparam int     QUIET_LIMIT   = 1000;
   localparam int     IDLE_PCT      = 28;
   localparam longint POS_MAX       = 64'sh7FFF_FFFF;
   localparam longint POS_MIN       = -64'sh8000_0000;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   uti_pkg::req_type           req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   uti_pkg::rsp_type           rsp_data;
   logic                       csr_write = 1'b0;
   logic [1:0]                 csr_index = uti_pkg::CSR_T_MIN;
   logic [uti_pkg::DATA_W-1:0] csr_wdata = '0;

   // where a lookup lands in the table
   typedef struct {
      logic [1:0]                    flag;
      int unsigned                   lo;
      int unsigned                   hi;
      logic [uti_pkg::FRAC_BITS-1:0] frac;
   } spot_type;

   // shadow of the block's registers and table
   logic signed [uti_pkg::DATA_W-1:0] t_min_reg = '0;
   logic [uti_pkg::DATA_W-1:0]        scale_reg = uti_pkg::SCALE_RESET;
   logic [uti_pkg::CNT_W-1:0]         count_reg = uti_pkg::COUNT_RESET;
   logic signed [uti_pkg::DATA_W-1:0] sample_mem [uti_pkg::TABLE_DEPTH];
   bit                                entry_loaded [uti_pkg::TABLE_DEPTH];

   uti_pkg::req_type req_backlog [$];
   uti_pkg::rsp_type expected_lookups [$];
   int               errors       = 0;
   int               queued       = 0;
   bit               calm         = 1'b0;
   int               quiet_cycles = 0;

   uniform_table_linear_interp dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int unsigned last_entry();
      int unsigned c;
      c = count_reg;
      if (c < 2) c = 2;
      if (c > uti_pkg::TABLE_DEPTH) c = uti_pkg::TABLE_DEPTH;
      return c - 1;
   endfunction

   function automatic spot_type locate(logic signed [uti_pkg::DATA_W-1:0] pos);
      spot_type                          s;
      logic signed [uti_pkg::DIFF_W-1:0] d;
      logic [uti_pkg::DIFF_W-1:0]        mag;
      logic [uti_pkg::PROD_W-1:0]        prod;
      logic [uti_pkg::WHOLE_W-1:0]       whole;
      int unsigned                       last;
      last   = last_entry();
      d      = {pos[uti_pkg::DATA_W-1], pos}
             - {t_min_reg[uti_pkg::DATA_W-1], t_min_reg};
      mag    = d[uti_pkg::DIFF_W-1] ? uti_pkg::DIFF_W'(-d) : uti_pkg::DIFF_W'(d);
      prod   = uti_pkg::PROD_W'(mag) * uti_pkg::PROD_W'(scale_reg);
      whole  = prod[uti_pkg::PROD_W-1 -: uti_pkg::WHOLE_W];
      s.frac = prod[2*uti_pkg::FRAC_BITS-1 -: uti_pkg::FRAC_BITS];
      s.flag = uti_pkg::FLAG_INSIDE;
      if (d[uti_pkg::DIFF_W-1] && prod != '0) begin
         s.flag = uti_pkg::FLAG_BELOW;
         s.lo   = 0;
         s.hi   = 0;
      end else if (whole > last || (whole == last && s.frac != '0)) begin
         s.flag = uti_pkg::FLAG_ABOVE;
         s.lo   = last;
         s.hi   = last;
      end else if (whole == last) begin
         s.lo = last;
         s.hi = last;
      end else begin
         s.lo = whole;
         s.hi = whole + 1;
      end
      return s;
   endfunction

   // blend rounds toward minus infinity: arithmetic shift of the signed product
   function automatic uti_pkg::rsp_type interpolate_entry(
         logic signed [uti_pkg::DATA_W-1:0] pos);
      spot_type         s;
      uti_pkg::rsp_type r;
      longint           e0;
      longint           e1;
      longint           step;
      s            = locate(pos);
      e0           = sample_mem[s.lo];
      e1           = sample_mem[s.hi];
      step         = ((e1 - e0) * longint'(s.frac)) >>> uti_pkg::FRAC_BITS;
      r.value      = uti_pkg::DATA_W'(e0 + step);
      r.clamp_flag = s.flag;
      return r;
   endfunction

   function automatic void add_write(int unsigned idx, logic [uti_pkg::DATA_W-1:0] val);
      uti_pkg::req_type r;
      r.op          = uti_pkg::OP_WRITE;
      r.position    = $urandom;
      r.entry_index = uti_pkg::INDEX_W'(idx);
      r.entry_value = val;
      req_backlog.insert(req_backlog.size(), r);
      entry_loaded[idx] = 1'b1;
      queued++;
   endfunction

   // fills any entry the lookup would read before queueing it
   function automatic void add_lookup(logic signed [uti_pkg::DATA_W-1:0] pos);
      spot_type         s;
      uti_pkg::req_type r;
      int unsigned      a;
      int               i;
      s = locate(pos);
      for (i = 0; i < 2; i++) begin
         a = (s.lo + i) % uti_pkg::TABLE_DEPTH;
         if (!entry_loaded[a]) add_write(a, $urandom);
      end
      r.op          = uti_pkg::OP_LOOKUP;
      r.position    = pos;
      r.entry_index = uti_pkg::INDEX_W'($urandom);
      r.entry_value = $urandom;
      req_backlog.insert(req_backlog.size(), r);
      queued++;
   endfunction

   // mostly positions around the table span, some near its ends, some anywhere
   function automatic logic signed [uti_pkg::DATA_W-1:0] pick_position();
      longint      span;
      longint      off;
      longint      p;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 20) return $urandom;
      if (scale_reg == '0) span = longint'(1) << 33;
      else span = (longint'(last_entry()) << 32) / longint'(scale_reg);
      if (span > (longint'(1) << 33)) span = longint'(1) << 33;
      if (span < 16) span = 16;
      if (roll < 28)
         off = (roll < 24 ? 0 : span) + longint'($urandom_range(16)) - 8;
      else
         off = longint'(64'({$urandom, $urandom}) % 64'(span + span / 4)) - span / 8;
      p = longint'(t_min_reg) + off;
      if (p > POS_MAX) p = POS_MAX;
      if (p < POS_MIN) p = POS_MIN;
      return uti_pkg::DATA_W'(p);
   endfunction

   task automatic write_csr(logic [1:0] idx, logic [uti_pkg::DATA_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         uti_pkg::CSR_T_MIN:       t_min_reg = val;
         uti_pkg::CSR_INDEX_SCALE: scale_reg = val;
         default:                  count_reg = val[uti_pkg::CNT_W-1:0];
      endcase
   endtask

   // sender holds off until every lookup has answered, then writes settle
   task automatic drain();
      do @(posedge clock);
      while (req_backlog.size() != 0 || expected_lookups.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // n counts every queued transaction, fill writes included
   task automatic run_phase(logic [uti_pkg::DATA_W-1:0] t_min,
                            logic [uti_pkg::DATA_W-1:0] scale,
                            logic [uti_pkg::DATA_W-1:0] count, int n, bit no_idle);
      int start;
      write_csr(uti_pkg::CSR_T_MIN, t_min);
      write_csr(uti_pkg::CSR_INDEX_SCALE, scale);
      write_csr(uti_pkg::CSR_ENTRY_COUNT, count);
      @(posedge clock);
      csr_write <= 1'b0;
      calm = no_idle;
      start = queued;
      while (queued - start < n) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(9) < 7) add_write($urandom_range(last_entry()), $urandom);
            else add_write($urandom_range(uti_pkg::TABLE_DEPTH - 1), $urandom);
         end else begin
            add_lookup(pick_position());
         end
      end
      drain();
      calm = 1'b0;
   endtask

   // driver: presents the oldest pending transaction, predicts on acceptance
   always @(posedge clock) begin : drive
      uti_pkg::req_type accepted;
      logic             show;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            accepted = req_backlog.pop_front();
            if (accepted.op == uti_pkg::OP_WRITE)
               sample_mem[accepted.entry_index] = accepted.entry_value;
            else
               expected_lookups.insert(expected_lookups.size(),
                                       interpolate_entry(accepted.position));
         end
         show = req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT);
         req_valid <= show;
         if (show) req_data <= req_backlog[0];
      end
   end

   always @(posedge clock) begin : observe
      uti_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               errors++;
               $display("%0t: response with no lookup pending, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_data.value !== want.value) begin
                  errors++;
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, want.value, rsp_data.value);
               end
               if (rsp_data.clamp_flag !== want.clamp_flag) begin
                  errors++;
                  $display("%0t: clamp_flag mismatch, expected %0d, actual %0d",
                           $time, want.clamp_flag, rsp_data.clamp_flag);
               end
            end
         end
         rsp_stall <= !calm && $urandom_range(99) < IDLE_PCT;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // register defaults: extreme entries, both clamps, exact last entry
      add_write(0, 32'h7FFF_FFFF);
      add_write(1, 32'h8000_0000);
      add_write(2, 32'h0000_0000);
      add_write(3, 32'h0001_0000);
      add_write(1022, 32'hFFFF_FFFF);
      add_write(1023, 32'h1234_5678);
      add_lookup(32'sh0000_0000);
      add_lookup(32'sh0000_8000);
      add_lookup(32'sh0000_0001);
      add_lookup(32'sh0001_FFFF);
      add_lookup(32'sh0002_4000);
      add_lookup(-32'sh1);
      add_lookup(32'sh8000_0000);
      add_lookup(32'sh03FE_C000);
      add_lookup(32'sh03FF_0000);
      add_lookup(32'sh03FF_0001);
      add_lookup(32'sh0400_0000);
      add_lookup(32'sh7FFF_FFFF);
      drain();

      run_phase(32'h0, uti_pkg::SCALE_RESET, 16, 90, 1'b0);
      run_phase(32'h8000_0000, 32'hFFFF_FFFF, 1024, 60, 1'b0);
      run_phase(32'h7FFF_FFFF, 32'h0, 2047, 40, 1'b0);
      run_phase($urandom, $urandom_range(1 << 22, 1 << 12), 0, 70, 1'b1);
      run_phase($urandom, $urandom_range(1 << 20, 1 << 8), 1, 60, 1'b0);
      run_phase($urandom, $urandom, 1024, 110, 1'b0);
      run_phase($urandom, $urandom_range(1 << 20), 1025, 80, 1'b0);
      run_phase($urandom, $urandom_range(1 << 24), $urandom_range(300, 2), 110, 1'b0);

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/uti_pkg.sv
src/uti_index.sv
src/uti_table.sv
src/uti_blend.sv
src/uniform_table_linear_interp.sv
dv/testbench.sv
